FILE: hdl/ccpsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpsd_pkg
// Shared types and constants for the charge comparison PSD block.
// ----------------------------------------------------------------------------
package ccpsd_pkg;

   localparam int TRACE_LENGTH_DEF = 512;
   localparam int SAMPLE_BITS      = 14;
   localparam int WIN_W            = 9;
   localparam int CHARGE_W         = 23;
   localparam int PSD_W            = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int DIV_STEPS        = PSD_W;
   localparam int STEP_W           = $clog2(DIV_STEPS);

   localparam logic [WIN_W-1:0] WINDOW_START_RST = WIN_W'(0);
   localparam logic [WIN_W-1:0] SHORT_END_RST    = WIN_W'(60);
   localparam logic [WIN_W-1:0] LONG_END_RST     = WIN_W'(250);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_START = 2'd0,
      CSR_SHORT_END    = 2'd1,
      CSR_LONG_END     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic sample_en;
      logic div_load;
      logic div_step;
      logic out_load;
   } ccpsd_cmd_type;

endpackage
`default_nettype wire

FILE: hdl/ccpsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpsd_ctrl
// Sequencer: sample accumulation, end-of-trace load, divide steps, result.
// ----------------------------------------------------------------------------
module ccpsd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last_sample,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output ccpsd_pkg::ccpsd_cmd_type     cmd
);
   import ccpsd_pkg::*;

   typedef enum logic [1:0] {
      ST_ACC,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_ACC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      cmd            = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_ACC: begin
            cmd.sample_en = req_valid;
            if (req_valid && req_last_sample) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ccpsd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpsd_dp
// Window registers, saturating integrators, restoring divider, result register.
// ----------------------------------------------------------------------------
module ccpsd_dp #(
   parameter int TRACE_LENGTH = ccpsd_pkg::TRACE_LENGTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ccpsd_pkg::ccpsd_cmd_type         cmd,
   input  wire logic                             csr_we,
   input  wire logic [ccpsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ccpsd_pkg::WIN_W-1:0]      csr_data,
   input  wire logic [ccpsd_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic [ccpsd_pkg::CHARGE_W-1:0]        rsp_charge,
   output logic [ccpsd_pkg::PSD_W-1:0]           rsp_psd_fraction,
   output logic                                  rsp_zero_charge
);
   import ccpsd_pkg::*;

   localparam int IDX_W = $clog2(TRACE_LENGTH + 1);
   localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;

   logic [WIN_W-1:0]    win_start_ff, short_end_ff, long_end_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CHARGE_W-1:0] long_ff, long_in, short_ff, short_in;
   logic [CHARGE_W-1:0] divisor_ff, divisor_in, rem_ff, rem_in;
   logic [PSD_W-1:0]    quo_ff, quo_in;
   logic                zero_ff, zero_in, full_ff, full_in;
   logic [CHARGE_W-1:0] charge_ff, charge_in;
   logic [PSD_W-1:0]    psd_ff, psd_in;
   logic                zflag_ff, zflag_in;

   logic [CMP_W-1:0]    idx_ext;
   logic                in_long, in_short;
   logic [CHARGE_W:0]   long_add, short_add;
   logic [CHARGE_W-1:0] long_sat, short_sat, short_clip;
   logic [CHARGE_W:0]   rem_shift, rem_diff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WINDOW_START_RST;
         short_end_ff <= SHORT_END_RST;
         long_end_ff  <= LONG_END_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_START: win_start_ff <= csr_data;
            CSR_SHORT_END:    short_end_ff <= csr_data;
            CSR_LONG_END:     long_end_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // integrators
   assign idx_ext  = CMP_W'(idx_ff);
   assign in_long  = (idx_ext < CMP_W'(TRACE_LENGTH)) && (idx_ext >= CMP_W'(win_start_ff))
                     && (idx_ext <= CMP_W'(long_end_ff));
   assign in_short = in_long && (idx_ext <= CMP_W'(short_end_ff));

   assign long_add  = {1'b0, long_ff} + (CHARGE_W+1)'(req_sample);
   assign short_add = {1'b0, short_ff} + (CHARGE_W+1)'(req_sample);
   assign long_sat  = long_add[CHARGE_W] ? '1 : long_add[CHARGE_W-1:0];
   assign short_sat = short_add[CHARGE_W] ? '1 : short_add[CHARGE_W-1:0];
   assign short_clip = (short_ff <= long_ff) ? short_ff : long_ff;

   // divider step: shift the remainder left and subtract the divisor when it fits
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      idx_in     = idx_ff;
      long_in    = long_ff;
      short_in   = short_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      zero_in    = zero_ff;
      full_in    = full_ff;
      charge_in  = charge_ff;
      psd_in     = psd_ff;
      zflag_in   = zflag_ff;

      if (cmd.sample_en) begin
         if (in_long) begin
            long_in = long_sat;
         end
         if (in_short) begin
            short_in = short_sat;
         end
         if (idx_ff != IDX_W'(TRACE_LENGTH)) begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (cmd.div_load) begin
         divisor_in = long_ff;
         rem_in     = long_ff - short_clip;
         quo_in     = '0;
         zero_in    = (long_ff == '0);
         full_in    = (short_clip == '0);
         idx_in     = '0;
         long_in    = '0;
         short_in   = '0;
      end

      if (cmd.div_step) begin
         if (!rem_diff[CHARGE_W]) begin
            rem_in = rem_diff[CHARGE_W-1:0];
            quo_in = {quo_ff[PSD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CHARGE_W-1:0];
            quo_in = {quo_ff[PSD_W-2:0], 1'b0};
         end
      end

      if (cmd.out_load) begin
         charge_in = divisor_ff;
         zflag_in  = zero_ff;
         if (zero_ff) begin
            psd_in = '0;
         end else if (full_ff) begin
            psd_in = '1;
         end else begin
            psd_in = quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         long_ff  <= '0;
         short_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         long_ff  <= long_in;
         short_ff <= short_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      zero_ff    <= zero_in;
      full_ff    <= full_in;
      charge_ff  <= charge_in;
      psd_ff     <= psd_in;
      zflag_ff   <= zflag_in;
   end

   assign rsp_charge       = charge_ff;
   assign rsp_psd_fraction = psd_ff;
   assign rsp_zero_charge  = zflag_ff;

endmodule
`default_nettype wire

FILE: hdl/charge_comparison_psd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// charge_comparison_psd
// Charge comparison pulse shape discrimination over one trace at a time.
//
//   channel | ports                                      | dir
//   req     | req_valid req_stall req_sample req_last_sample | in
//   rsp     | rsp_valid rsp_stall rsp_charge rsp_psd_fraction rsp_zero_charge | out
//   csr     | csr_valid csr_ready csr_index csr_data     | in
//
// One sample per cycle is transferred while a trace is integrated.
// After the last sample, req_stall is held through a load state, the 16 steps
// of the shift-subtract divider and a state that loads the result.
// The result load waits while a previous result is still stalled.
// Synchronous reset clears sums, index and the sequencer and restores the
// default windows.
// ----------------------------------------------------------------------------
module charge_comparison_psd #(
   parameter int TRACE_LENGTH = ccpsd_pkg::TRACE_LENGTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ccpsd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                              req_last_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ccpsd_pkg::CHARGE_W-1:0]         rsp_charge,
   output logic [ccpsd_pkg::PSD_W-1:0]            rsp_psd_fraction,
   output logic                                   rsp_zero_charge,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ccpsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccpsd_pkg::WIN_W-1:0]       csr_data
);
   import ccpsd_pkg::*;

   ccpsd_cmd_type cmd;

   assign csr_ready = 1'b1;

   ccpsd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd)
   );

   ccpsd_dp #(
      .TRACE_LENGTH (TRACE_LENGTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_sample       (req_sample),
      .rsp_charge       (rsp_charge),
      .rsp_psd_fraction (rsp_psd_fraction),
      .rsp_zero_charge  (rsp_zero_charge)
   );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for charge_comparison_psd. Traces of digitizer samples
// are sent under random sender gaps and receiver stalls; a behavioral copy of
// the window integrals and the tail-fraction divide predicts each per-trace
// result, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ccpsd_pkg::*;

   localparam int TRACE_SAMPLES = TRACE_LENGTH_DEF;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam logic [CHARGE_W-1:0]    CHARGE_MAX = '1;
   localparam logic [PSD_W-1:0]       PSD_MAX    = '1;
   localparam logic [WIN_W-1:0]       WIN_MAX    = '1;
   localparam logic [CSR_IDX_W-1:0]   CSR_SPARE  = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [CHARGE_W-1:0] charge;
      logic [PSD_W-1:0]    psd_fraction;
      logic                zero_charge;
   } pulse_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   req_last_sample = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHARGE_W-1:0]    rsp_charge;
   logic [PSD_W-1:0]       rsp_psd_fraction;
   logic                   rsp_zero_charge;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [WIN_W-1:0]       csr_data = '0;

   // window registers and running integrals as the block should hold them
   logic [WIN_W-1:0]    win_start = WINDOW_START_RST;
   logic [WIN_W-1:0]    win_short_end = SHORT_END_RST;
   logic [WIN_W-1:0]    win_long_end = LONG_END_RST;
   logic [WIN_W:0]      trace_pos = '0;
   logic [CHARGE_W-1:0] long_acc = '0;
   logic [CHARGE_W-1:0] short_acc = '0;

   pulse_result_type       pulse_results[$];
   pulse_result_type       oldest;
   logic [SAMPLE_BITS-1:0] trace_buf[$];
   int                     errors = 0;
   int                     req_gap_pct = 11;
   int                     rsp_stall_pct = 57;
   int                     hold_requests = 0;
   int                     hold_served = 0;
   int                     hold_left = 0;

   charge_comparison_psd #(.TRACE_LENGTH(TRACE_SAMPLES)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_charge      (rsp_charge),
      .rsp_psd_fraction(rsp_psd_fraction),
      .rsp_zero_charge (rsp_zero_charge),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [CHARGE_W-1:0] add_clamped(input logic [CHARGE_W-1:0] acc,
                                                        input logic [SAMPLE_BITS-1:0] amp);
      logic [CHARGE_W:0] total;
      total = acc + amp;
      return (total > CHARGE_MAX) ? CHARGE_MAX : total[CHARGE_W-1:0];
   endfunction

   // integrates one sample; on the last sample of a trace returns 1 with the trace result
   function automatic bit integrate_sample(input logic [SAMPLE_BITS-1:0] amp,
                                           input logic last, output pulse_result_type res);
      logic [CHARGE_W-1:0] short_clip;
      longint unsigned     ratio;
      res = '0;
      if (trace_pos < TRACE_SAMPLES && trace_pos >= win_start && trace_pos <= win_long_end) begin
         long_acc = add_clamped(long_acc, amp);
         if (trace_pos <= win_short_end) begin
            short_acc = add_clamped(short_acc, amp);
         end
      end
      if (trace_pos < TRACE_SAMPLES) begin
         trace_pos = trace_pos + 1'b1;
      end
      if (!last) begin
         return 1'b0;
      end
      short_clip = (short_acc <= long_acc) ? short_acc : long_acc;
      res.charge = long_acc;
      if (long_acc == '0) begin
         res.zero_charge = 1'b1;
      end else begin
         ratio = (longint'(long_acc - short_clip) << 16) / longint'(long_acc);
         res.psd_fraction = (ratio > PSD_MAX) ? PSD_MAX : PSD_W'(ratio);
      end
      trace_pos = '0;
      long_acc  = '0;
      short_acc = '0;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_amplitude();
      case ($urandom_range(9))
         0: return '0;
         1: return SAMPLE_MAX;
         default: return SAMPLE_BITS'($urandom_range(int'(SAMPLE_MAX)));
      endcase
   endfunction

   function automatic logic [WIN_W-1:0] random_window_edge();
      case ($urandom_range(9))
         0: return '0;
         1: return WIN_MAX;
         2: return WIN_W'($urandom_range(int'(WIN_MAX)));
         default: return WIN_W'($urandom_range(48));
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] amp, input logic last);
      pulse_result_type res;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= amp;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (integrate_sample(amp, last, res)) begin
         pulse_results.push_back(res);
      end
   endtask

   task automatic send_trace(input int len, input bit flat);
      for (int i = 0; i < len; i++) begin
         send_sample(flat ? SAMPLE_MAX : random_amplitude(), i == len - 1);
      end
   endtask

   task automatic send_buffered_trace();
      foreach (trace_buf[i]) begin
         send_sample(trace_buf[i], i == trace_buf.size() - 1);
      end
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_window(input csr_index_type which, input logic [WIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (which)
         CSR_WINDOW_START: win_start = value;
         CSR_SHORT_END:    win_short_end = value;
         CSR_LONG_END:     win_long_end = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [WIN_W-1:0] start_idx, input logic [WIN_W-1:0] short_idx,
                            input logic [WIN_W-1:0] long_idx);
      write_window(CSR_WINDOW_START, start_idx);
      write_window(CSR_SHORT_END, short_idx);
      write_window(CSR_LONG_END, long_idx);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pulse_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_window_cases();
      // reset windows, fraction zero, then an all-zero trace
      trace_buf = {SAMPLE_MAX, 14'd0, 14'd8191, SAMPLE_MAX};
      send_buffered_trace();
      trace_buf = {14'd0};
      send_buffered_trace();
      settle();
      configure(9'd2, 9'd3, 9'd6);
      trace_buf = {SAMPLE_MAX, SAMPLE_MAX, 14'h2AAA, 14'h1555, 14'd1, SAMPLE_MAX, 14'd7,
                   SAMPLE_MAX};
      send_buffered_trace();
      // short window empty: tail fraction of one
      settle();
      configure(9'd4, 9'd2, 9'd7);
      trace_buf = {14'd5, 14'd5, 14'd5, 14'd5, 14'd3, 14'd0, 14'd0, 14'd1};
      send_buffered_trace();
      // short window reaching past the long one
      settle();
      configure(9'd0, 9'd9, 9'd3);
      trace_buf = {14'd1, 14'd2, 14'd3, 14'd4, 14'd100};
      send_buffered_trace();
      // both windows empty; the spare index must change nothing
      settle();
      write_window(csr_index_type'(CSR_SPARE), WIN_MAX);
      configure(9'd10, 9'd20, 9'd5);
      trace_buf = {14'd9, 14'd9};
      send_buffered_trace();
   endtask

   task automatic test_overlong_traces();
      settle();
      configure(9'd0, 9'd0, WIN_MAX);
      send_trace(TRACE_SAMPLES + 2, 1'b1);
   endtask

   task automatic test_output_backpressure();
      settle();
      configure(9'd0, 9'd1, 9'd2);
      hold_requests <= hold_requests + 1;
      repeat (8) send_trace(3, 1'b0);
   endtask

   task automatic run_random_phase(input int gap_pct, input int stall_pct);
      int items;
      int traces;
      int len;
      int pick;
      req_gap_pct    = gap_pct;
      rsp_stall_pct <= stall_pct;
      items  = 0;
      traces = 0;
      while (items < 24 || traces < 4) begin
         if (traces % 2 == 0) begin
            settle();
            configure(random_window_edge(), random_window_edge(), random_window_edge());
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = $urandom_range(1, 8);
         end else begin
            len = $urandom_range(9, 24);
         end
         send_trace(len, 1'b0);
         items += len;
         traces++;
      end
   endtask

   task automatic test_random_traces();
      run_random_phase(11, 57);
      run_random_phase(57, 11);
      run_random_phase(0, 0);
   endtask

   // result checker and receiver stall generator
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulse_results.size() == 0) begin
            $error("result transfer with no trace pending: charge %0d", rsp_charge);
            errors++;
         end else begin
            oldest = pulse_results.pop_front();
            if (rsp_charge !== oldest.charge) begin
               $error("charge: expected %0d, actual %0d", oldest.charge, rsp_charge);
               errors++;
            end
            if (rsp_psd_fraction !== oldest.psd_fraction) begin
               $error("psd_fraction: expected %0d, actual %0d", oldest.psd_fraction,
                      rsp_psd_fraction);
               errors++;
            end
            if (rsp_zero_charge !== oldest.zero_charge) begin
               $error("zero_charge: expected %0d, actual %0d", oldest.zero_charge,
                      rsp_zero_charge);
               errors++;
            end
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_window_cases();
      test_overlong_traces();
      test_output_backpressure();
      test_random_traces();
      settle();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
